// ----- rtl/core/knnsel_pkg.sv -----
// Shared types, widths, codes and the ordering helper for the k-nearest-neighbor selector.
// Used by the controller, the datapath and the top level. No dependencies.

package knnsel_pkg;

   // Sizes of the list, the point dimension and the payload fields.
   localparam int MAX_NEIGHBORS = 16;
   localparam int MAX_DIMENSION = 1024;
   localparam int COORD_BITS    = 16;
   localparam int ID_BITS       = 20;

   localparam int SLOT_BITS     = $clog2(MAX_NEIGHBORS);
   localparam int COUNT_BITS    = 5;
   localparam int K_BITS        = 5;
   localparam int DIM_BITS      = 11;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int SQ_BITS       = 2 * COORD_BITS;
   localparam int DIST_BITS     = 44;
   localparam int OUT_DIST_BITS = 43;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 11;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NEIGHBOR_COUNT   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VECTOR_DIMENSION = 1'd1;
   localparam logic [K_BITS-1:0]         RESET_NEIGHBOR_COUNT = 5'd8;
   localparam logic [DIM_BITS-1:0]       RESET_DIMENSION      = 11'd128;

   // Request opcodes and result kinds.
   localparam logic OP_COORD    = 1'b0;
   localparam logic OP_READOUT  = 1'b1;
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 acc_en;
      logic                 acc_clear;
      logic                 insert_en;
      logic                 worst_step;
      logic                 best_step;
      logic                 scan_first;
      logic [SLOT_BITS-1:0] scan_idx;
      logic                 load_report;
      logic                 load_entry;
      logic                 load_empty;
      logic                 entry_last;
      logic                 mark_emitted;
      logic                 clear_list;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic                  point_done;
      logic                  will_accept;
      logic [COUNT_BITS-1:0] total;
      logic                  out_free;
   } dp_status_type;

   // True if the pair (da, ia) orders strictly before (db, ib).
   function automatic logic better(input logic [DIST_BITS-1:0] da,
                                   input logic [ID_BITS-1:0]   ia,
                                   input logic [DIST_BITS-1:0] db,
                                   input logic [ID_BITS-1:0]   ib);
      return (da < db) || ((da == db) && (ia < ib));
   endfunction

endpackage

// ----- rtl/core/knnsel_ctrl.sv -----
// Controller state machine of the k-nearest-neighbor selector.
// Depends on knnsel_pkg for the command and status structs and the opcodes.

module knnsel_ctrl import knnsel_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_opcode,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_INSERT    = 3'd1;
   localparam logic [2:0] S_WORST     = 3'd2;
   localparam logic [2:0] S_REPORT    = 3'd3;
   localparam logic [2:0] S_EMPTY     = 3'd4;
   localparam logic [2:0] S_SORT_SCAN = 3'd5;
   localparam logic [2:0] S_SORT_EMIT = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [SLOT_BITS-1:0] round_ff, round_in;
   logic                 scan_last;
   logic                 round_last;
   logic                 req_take;

   // Scans and read-out rounds run over the hits currently held.
   assign scan_last  = (COUNT_BITS'(idx_ff) + COUNT_BITS'(1)) == status.total;
   assign round_last = (COUNT_BITS'(round_ff) + COUNT_BITS'(1)) == status.total;
   assign req_ready  = (state_ff == S_IDLE);
   assign req_take   = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      round_in = round_ff;
      cmd      = '0;
      cmd.scan_idx   = idx_ff;
      cmd.scan_first = (idx_ff == '0);
      cmd.entry_last = round_last;
      case (state_ff)
         S_IDLE: begin
            idx_in   = '0;
            round_in = '0;
            if (req_take) begin
               if (req_opcode == OP_READOUT) begin
                  cmd.acc_clear = 1'b1;
                  state_in = (status.total == '0) ? S_EMPTY : S_SORT_SCAN;
               end else begin
                  cmd.acc_en = 1'b1;
                  if (status.point_done) begin
                     state_in = S_INSERT;
                  end
               end
            end
         end
         S_INSERT: begin
            cmd.insert_en = 1'b1;
            idx_in   = '0;
            state_in = status.will_accept ? S_WORST : S_REPORT;
         end
         S_WORST: begin
            cmd.worst_step = 1'b1;
            if (scan_last) begin
               state_in = S_REPORT;
            end else begin
               idx_in = idx_ff + SLOT_BITS'(1);
            end
         end
         S_REPORT: begin
            if (status.out_free) begin
               cmd.load_report = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (status.out_free) begin
               cmd.load_empty = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SORT_SCAN: begin
            cmd.best_step = 1'b1;
            if (scan_last) begin
               state_in = S_SORT_EMIT;
            end else begin
               idx_in = idx_ff + SLOT_BITS'(1);
            end
         end
         S_SORT_EMIT: begin
            if (status.out_free) begin
               cmd.load_entry   = 1'b1;
               cmd.mark_emitted = 1'b1;
               idx_in = '0;
               if (round_last) begin
                  cmd.clear_list = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  round_in = round_ff + SLOT_BITS'(1);
                  state_in = S_SORT_SCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         round_ff <= round_in;
      end
   end

endmodule

// ----- rtl/core/knnsel_dp.sv -----
// Datapath of the k-nearest-neighbor selector: distance accumulator, hit list,
// worst and best scans, configuration registers and the result register.
// Depends on knnsel_pkg for widths, codes, structs and the ordering helper.

module knnsel_dp import knnsel_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic [ID_BITS-1:0]        req_candidate_id,
   input  logic signed [COORD_BITS-1:0] req_point_coord,
   input  logic signed [COORD_BITS-1:0] req_query_coord,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_result_kind,
   output logic [ID_BITS-1:0]        rsp_hit_id,
   output logic [OUT_DIST_BITS-1:0]  rsp_hit_distance,
   output logic                      rsp_was_accepted,
   output logic [OUT_DIST_BITS-1:0]  rsp_search_radius,
   output logic                      rsp_radius_valid,
   output logic [COUNT_BITS-1:0]     rsp_hits_held,
   output logic                      rsp_entry_valid,
   output logic                      rsp_last_entry
);

   // Configuration registers.
   logic [K_BITS-1:0]   neighbor_count_ff, neighbor_count_in;
   logic [DIM_BITS-1:0] dimension_ff, dimension_in;

   // Accumulator.
   logic [DIST_BITS-1:0] sum_ff, sum_in;
   logic [DIM_BITS-1:0]  index_ff, index_in;
   logic [DIM_BITS-1:0]  index_next;
   logic [DIM_BITS-1:0]  dim_eff;
   logic signed [DIFF_BITS-1:0]   diff;
   logic signed [2*DIFF_BITS-1:0] square;
   logic [DIST_BITS-1:0] sum_next;

   // Finished point.
   logic [DIST_BITS-1:0] dist_ff, dist_in;
   logic [ID_BITS-1:0]   pid_ff, pid_in;
   logic                 accepted_ff, accepted_in;

   // Hit list.
   logic [DIST_BITS-1:0]  hit_dist_ff [MAX_NEIGHBORS];
   logic [ID_BITS-1:0]    hit_id_ff [MAX_NEIGHBORS];
   logic                  hit_we;
   logic [SLOT_BITS-1:0]  hit_slot;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [MAX_NEIGHBORS-1:0] emitted_ff, emitted_in;
   logic [COUNT_BITS-1:0] k_eff;
   logic                  list_open;
   logic                  will_accept;
   logic [DIST_BITS-1:0]  rd_dist;
   logic [ID_BITS-1:0]    rd_id;

   // Worst and best trackers.
   logic [SLOT_BITS-1:0] worst_idx_ff, worst_idx_in;
   logic [DIST_BITS-1:0] worst_dist_ff, worst_dist_in;
   logic [ID_BITS-1:0]   worst_id_ff, worst_id_in;
   logic [SLOT_BITS-1:0] best_idx_ff, best_idx_in;
   logic [DIST_BITS-1:0] best_dist_ff, best_dist_in;
   logic [ID_BITS-1:0]   best_id_ff, best_id_in;
   logic                 best_valid_ff, best_valid_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     kind_ff, kind_in;
   logic [ID_BITS-1:0]       out_id_ff, out_id_in;
   logic [OUT_DIST_BITS-1:0] out_dist_ff, out_dist_in;
   logic                     out_acc_ff, out_acc_in;
   logic [OUT_DIST_BITS-1:0] radius_ff, radius_in;
   logic                     radius_valid_ff, radius_valid_in;
   logic [COUNT_BITS-1:0]    held_ff, held_in;
   logic                     entry_valid_ff, entry_valid_in;
   logic                     last_ff, last_in;
   logic [OUT_DIST_BITS-1:0] radius_now;
   logic                     radius_valid_now;
   logic                     out_load;

   // Configuration writes, with k and the dimension clamped to their ranges.
   always_comb begin
      neighbor_count_in = neighbor_count_ff;
      dimension_in      = dimension_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_NEIGHBOR_COUNT:   neighbor_count_in = csr_write_data[K_BITS-1:0];
            REG_VECTOR_DIMENSION: dimension_in      = csr_write_data[DIM_BITS-1:0];
            default: ;
         endcase
      end
      if (neighbor_count_ff > K_BITS'(MAX_NEIGHBORS)) begin
         k_eff = COUNT_BITS'(MAX_NEIGHBORS);
      end else begin
         k_eff = COUNT_BITS'(neighbor_count_ff);
      end
      if (dimension_ff == '0) begin
         dim_eff = DIM_BITS'(1);
      end else if (dimension_ff > DIM_BITS'(MAX_DIMENSION)) begin
         dim_eff = DIM_BITS'(MAX_DIMENSION);
      end else begin
         dim_eff = dimension_ff;
      end
   end

   // Squared difference and running sum of one point.
   assign diff       = DIFF_BITS'(req_point_coord) - DIFF_BITS'(req_query_coord);
   assign square     = diff * diff;
   assign sum_next   = sum_ff + DIST_BITS'(square[SQ_BITS-1:0]);
   assign index_next = index_ff + DIM_BITS'(1);

   always_comb begin
      sum_in   = sum_ff;
      index_in = index_ff;
      dist_in  = dist_ff;
      pid_in   = pid_ff;
      if (cmd.acc_clear) begin
         sum_in   = '0;
         index_in = '0;
      end else if (cmd.acc_en) begin
         if (index_next >= dim_eff) begin
            sum_in   = '0;
            index_in = '0;
            dist_in  = sum_next;
            pid_in   = req_candidate_id;
         end else begin
            sum_in   = sum_next;
            index_in = index_next;
         end
      end
   end

   // Insertion decision: append while room is left, else replace the worst hit if the new point orders before it.
   assign list_open   = total_ff < k_eff;
   assign will_accept = (k_eff != '0) &&
                        (list_open || better(dist_ff, pid_ff, worst_dist_ff, worst_id_ff));
   assign hit_slot    = list_open ? total_ff[SLOT_BITS-1:0] : worst_idx_ff;
   assign hit_we      = cmd.insert_en && will_accept;

   always_comb begin
      accepted_in = accepted_ff;
      total_in    = total_ff;
      emitted_in  = emitted_ff;
      if (cmd.insert_en) begin
         accepted_in = will_accept;
         if (will_accept && list_open) begin
            total_in = total_ff + COUNT_BITS'(1);
         end
      end
      if (cmd.mark_emitted) begin
         emitted_in[best_idx_ff] = 1'b1;
      end
      if (cmd.clear_list) begin
         total_in   = '0;
         emitted_in = '0;
      end
   end

   // One list entry is read per cycle at the scan position.
   assign rd_dist = hit_dist_ff[cmd.scan_idx];
   assign rd_id   = hit_id_ff[cmd.scan_idx];

   // Worst scan after a change, best scan over entries not yet read out.
   always_comb begin
      worst_idx_in  = worst_idx_ff;
      worst_dist_in = worst_dist_ff;
      worst_id_in   = worst_id_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      best_id_in    = best_id_ff;
      best_valid_in = best_valid_ff;
      if (cmd.worst_step) begin
         if (cmd.scan_first || better(worst_dist_ff, worst_id_ff, rd_dist, rd_id)) begin
            worst_idx_in  = cmd.scan_idx;
            worst_dist_in = rd_dist;
            worst_id_in   = rd_id;
         end
      end
      if (cmd.best_step) begin
         if (cmd.scan_first) begin
            best_valid_in = 1'b0;
         end
         if (!emitted_ff[cmd.scan_idx] &&
             (cmd.scan_first || !best_valid_ff ||
              better(rd_dist, rd_id, best_dist_ff, best_id_ff))) begin
            best_idx_in   = cmd.scan_idx;
            best_dist_in  = rd_dist;
            best_id_in    = rd_id;
            best_valid_in = 1'b1;
         end
      end
   end

   // Radius fields of the list as it stands.
   assign radius_now       = (total_ff != '0) ? worst_dist_ff[OUT_DIST_BITS-1:0] : '0;
   assign radius_valid_now = total_ff >= k_eff;
   assign out_load         = cmd.load_report || cmd.load_entry || cmd.load_empty;

   // Result register: loads when free or when the held result is taken.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      kind_in         = kind_ff;
      out_id_in       = out_id_ff;
      out_dist_in     = out_dist_ff;
      out_acc_in      = out_acc_ff;
      radius_in       = radius_ff;
      radius_valid_in = radius_valid_ff;
      held_in         = held_ff;
      entry_valid_in  = entry_valid_ff;
      last_in         = last_ff;
      if (out_load) begin
         rsp_valid_in    = 1'b1;
         radius_in       = radius_now;
         radius_valid_in = radius_valid_now;
         held_in         = total_ff;
         entry_valid_in  = 1'b1;
         last_in         = 1'b0;
      end
      if (cmd.load_report) begin
         kind_in     = KIND_REPORT;
         out_id_in   = pid_ff;
         out_dist_in = dist_ff[OUT_DIST_BITS-1:0];
         out_acc_in  = accepted_ff;
      end
      if (cmd.load_entry) begin
         kind_in     = KIND_ENTRY;
         out_id_in   = best_id_ff;
         out_dist_in = best_dist_ff[OUT_DIST_BITS-1:0];
         out_acc_in  = 1'b0;
         last_in     = cmd.entry_last;
      end
      if (cmd.load_empty) begin
         kind_in         = KIND_ENTRY;
         out_id_in       = '0;
         out_dist_in     = '0;
         out_acc_in      = 1'b0;
         radius_in       = '0;
         radius_valid_in = 1'b0;
         held_in         = '0;
         entry_valid_in  = 1'b0;
         last_in         = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         neighbor_count_ff <= RESET_NEIGHBOR_COUNT;
         dimension_ff      <= RESET_DIMENSION;
         sum_ff            <= '0;
         index_ff          <= '0;
         total_ff          <= '0;
         emitted_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         neighbor_count_ff <= neighbor_count_in;
         dimension_ff      <= dimension_in;
         sum_ff            <= sum_in;
         index_ff          <= index_in;
         total_ff          <= total_in;
         emitted_ff        <= emitted_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dist_ff         <= dist_in;
      pid_ff          <= pid_in;
      accepted_ff     <= accepted_in;
      worst_idx_ff    <= worst_idx_in;
      worst_dist_ff   <= worst_dist_in;
      worst_id_ff     <= worst_id_in;
      best_idx_ff     <= best_idx_in;
      best_dist_ff    <= best_dist_in;
      best_id_ff      <= best_id_in;
      best_valid_ff   <= best_valid_in;
      kind_ff         <= kind_in;
      out_id_ff       <= out_id_in;
      out_dist_ff     <= out_dist_in;
      out_acc_ff      <= out_acc_in;
      radius_ff       <= radius_in;
      radius_valid_ff <= radius_valid_in;
      held_ff         <= held_in;
      entry_valid_ff  <= entry_valid_in;
      last_ff         <= last_in;
      if (hit_we) begin
         hit_dist_ff[hit_slot] <= dist_ff;
         hit_id_ff[hit_slot]   <= pid_ff;
      end
   end

   assign status.point_done  = index_next >= dim_eff;
   assign status.will_accept = will_accept;
   assign status.total       = total_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_hit_id        = out_id_ff;
   assign rsp_hit_distance  = out_dist_ff;
   assign rsp_was_accepted  = out_acc_ff;
   assign rsp_search_radius = radius_ff;
   assign rsp_radius_valid  = radius_valid_ff;
   assign rsp_hits_held     = held_ff;
   assign rsp_entry_valid   = entry_valid_ff;
   assign rsp_last_entry    = last_ff;

endmodule

// ----- rtl/core/knn_distance_topk_selector.sv -----
// Top level of the k-nearest-neighbor selector: controller plus datapath.
// Depends on knnsel_pkg, knnsel_ctrl and knnsel_dp.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    opcode, candidate_id, point_coord, query_coord
//   rsp_      out        rsp_valid/rsp_ready    kind, id, distance, radius, flags
//   csr_      in         csr_write_enable       csr_index, csr_write_data
//
// A coordinate that does not finish a point is taken and the controller stays idle. A
// finishing coordinate inserts the point; when it enters the list, a scan at one entry per
// cycle finds the new worst hit and the report follows; a point turned away goes straight
// to the report. A read-out does one list scan per entry emitted, best first; an empty
// read-out gives a single empty result. Reset is synchronous: empty list, k = 8,
// dimension 128. A result waiting on rsp_ready holds the controller, and so the request.

module knn_distance_topk_selector import knnsel_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [ID_BITS-1:0]        req_candidate_id,
   input  logic signed [COORD_BITS-1:0] req_point_coord,
   input  logic signed [COORD_BITS-1:0] req_query_coord,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_result_kind,
   output logic [ID_BITS-1:0]        rsp_hit_id,
   output logic [OUT_DIST_BITS-1:0]  rsp_hit_distance,
   output logic                      rsp_was_accepted,
   output logic [OUT_DIST_BITS-1:0]  rsp_search_radius,
   output logic                      rsp_radius_valid,
   output logic [COUNT_BITS-1:0]     rsp_hits_held,
   output logic                      rsp_entry_valid,
   output logic                      rsp_last_entry
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencing of requests, scans and read-out rounds.
   knnsel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Accumulator, hit list and result register.
   knnsel_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_candidate_id  (req_candidate_id),
      .req_point_coord   (req_point_coord),
      .req_query_coord   (req_query_coord),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_hit_id        (rsp_hit_id),
      .rsp_hit_distance  (rsp_hit_distance),
      .rsp_was_accepted  (rsp_was_accepted),
      .rsp_search_radius (rsp_search_radius),
      .rsp_radius_valid  (rsp_radius_valid),
      .rsp_hits_held     (rsp_hits_held),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_last_entry    (rsp_last_entry)
   );

`ifndef SYNTHESIS
   // The list never reports more hits than it can hold.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hits_held <= COUNT_BITS'(MAX_NEIGHBORS))
      else $error("hits_held exceeds list size");

   // Only the empty read-out result carries entry_valid low, and it ends its run.
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |->
         rsp_last_entry && rsp_result_kind == KIND_ENTRY && rsp_hits_held == '0)
      else $error("malformed empty read-out result");

   // A distance report is never marked as the end of a read-out.
   a_report_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_REPORT |-> !rsp_last_entry && rsp_entry_valid)
      else $error("distance report carries read-out flags");

   // An accepted point lies inside the radius of a full list.
   a_accept_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_REPORT && rsp_was_accepted && rsp_radius_valid
         |-> rsp_hit_distance <= rsp_search_radius)
      else $error("accepted point lies outside the search radius");
`endif

endmodule
